// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BMB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BMB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/bmb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmb_pkg
// Types, sizes and constants of the box mean blur filter.
// ----------------------------------------------------------------------------
package bmb_pkg;

  localparam int MAX_KERNEL = 7;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int LINE_ROWS  = MAX_KERNEL - 1;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 10;
  localparam int COL_W   = 10;
  localparam int KERN_W  = 3;
  localparam int DIM_W   = 11;
  localparam int SLOT_W  = $clog2(LINE_ROWS);
  localparam int DIST_W  = SLOT_W + 1;
  localparam int LINE_W  = LINE_ROWS * PIX_W;
  localparam int VSUM_W  = 11;
  localparam int WSUM_W  = 14;

  // Reciprocal divide: floor(x / k^2) == (x * RECIP) >> DIV_SHIFT for x < 2^WSUM_W
  localparam int DIV_SHIFT = 20;
  localparam int RECIP_W   = 17;
  localparam int PROD_W    = WSUM_W + RECIP_W;
  localparam int RECIP_3   = ((1 << DIV_SHIFT) + 9 - 1) / 9;
  localparam int RECIP_5   = ((1 << DIV_SHIFT) + 25 - 1) / 25;
  localparam int RECIP_7   = ((1 << DIV_SHIFT) + 49 - 1) / 49;

  // Legal kernel sides
  localparam logic [KERN_W-1:0] KERNEL_3 = 3'd3;
  localparam logic [KERN_W-1:0] KERNEL_5 = 3'd5;
  localparam logic [KERN_W-1:0] KERNEL_7 = 3'd7;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_KERNEL = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [KERN_W-1:0] KERNEL_RST = KERNEL_3;
  localparam logic [DIM_W-1:0]  WIDTH_RST  = 11'd640;
  localparam logic [DIM_W-1:0]  HEIGHT_RST = 11'd480;
  localparam logic [DIM_W-1:0]  DIM_MIN    = 11'd8;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } pix_in_t;

  typedef struct packed {
    logic [ROW_W-1:0] centre_row;
    logic [COL_W-1:0] centre_col;
    logic [PIX_W-1:0] blurred;
    logic             interior;
  } blur_out_t;

  function automatic logic [RECIP_W-1:0] kernel_recip(input logic [KERN_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      KERNEL_5: r = RECIP_W'(RECIP_5);
      KERNEL_7: r = RECIP_W'(RECIP_7);
      default:  r = RECIP_W'(RECIP_3);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/bmb_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmb_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module bmb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/box_mean_blur.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_mean_blur
// Streaming box filter: truncated mean of an odd k x k window per pixel.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order and returns one result per
// pixel through the line store, column sum, window sum, product and output
// registers; the pipeline freezes only while a result waits under out_stall.
// One RAM word holds a column of the last six rows, read as the pixel enters
// and written back from stage 1: one read and one write per pixel, which sets
// the throughput. The line store is not cleared after reset; the first rows of
// a frame read no row unwritten in that frame. Configuration (kernel_size at
// 0x0, image_width at 0x4, image_height at 0x8) must be written by the user
// only while the stream is idle (unchecked); out-of-range writes are ignored.
module box_mean_blur import bmb_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire pix_in_t    in_data,
  output logic            out_valid,
  input  wire logic       out_stall,
  output blur_out_t       out_data,
  input  wire logic       psel,
  input  wire logic       penable,
  input  wire logic       pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  // Configuration registers
  logic [KERN_W-1:0] kernel_r;
  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic              cfg_wr;

  // Position of the next pixel
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [SLOT_W-1:0] cur_slot;
  logic [COL_W:0]    col_inc;
  logic [ROW_W:0]    row_inc;

  logic advance;
  logic in_acc;

  // Stage 1: line store word in flight
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pixel_r;
  logic [ROW_W-1:0]  s1_row_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic              byp_hit_r;
  logic [LINE_W-1:0] byp_word_r;
  logic [LINE_W-1:0] ram_rdata;
  logic [LINE_W-1:0] line_word;
  logic [LINE_W-1:0] wr_word;
  logic              wr_en;
  logic [VSUM_W-1:0] vsum;
  logic [KERN_W-1:0] half_k;
  logic [ROW_W-1:0]  s1_crow;
  logic [COL_W-1:0]  s1_ccol;
  logic              s1_inside;

  // Stage 2: column sums
  logic [VSUM_W-1:0] colsum_r [MAX_KERNEL];
  logic              s2_valid_r;
  logic [ROW_W-1:0]  s2_crow_r;
  logic [COL_W-1:0]  s2_ccol_r;
  logic              s2_inside_r;
  logic [WSUM_W-1:0] wsum;

  // Stage 3: window sum
  logic              s3_valid_r;
  logic [ROW_W-1:0]  s3_crow_r;
  logic [COL_W-1:0]  s3_ccol_r;
  logic              s3_inside_r;
  logic [WSUM_W-1:0] wsum_r;

  // Stage 4: reciprocal product
  logic              s4_valid_r;
  logic [ROW_W-1:0]  s4_crow_r;
  logic [COL_W-1:0]  s4_ccol_r;
  logic              s4_inside_r;
  logic [PROD_W-1:0] prod_r;

  logic              out_valid_r;
  blur_out_t         out_data_r;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_r <= KERNEL_RST;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_KERNEL: begin
          if (pwdata >= 32'(KERNEL_3) && pwdata[0] && pwdata <= 32'(MAX_KERNEL)) begin
            kernel_r <= pwdata[KERN_W-1:0];
          end
        end
        REG_WIDTH: begin
          if (pwdata >= 32'(DIM_MIN) && pwdata <= 32'(MAX_WIDTH)) begin
            width_r <= pwdata[DIM_W-1:0];
          end
        end
        REG_HEIGHT: begin
          if (pwdata >= 32'(DIM_MIN) && pwdata <= 32'(MAX_HEIGHT)) begin
            height_r <= pwdata[DIM_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_KERNEL: prdata = {29'd0, kernel_r};
      REG_WIDTH:  prdata = {21'd0, width_r};
      REG_HEIGHT: prdata = {21'd0, height_r};
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Flow control: the whole pipeline holds while a result is stalled
  // --------------------------------------------------------------------------
  assign in_stall = out_valid_r & out_stall;
  assign advance  = ~in_stall;
  assign in_acc   = advance & in_valid;

  // --------------------------------------------------------------------------
  // Raster position
  // --------------------------------------------------------------------------
  assign cur_row  = in_data.frame_start ? '0 : row_r;
  assign cur_col  = in_data.frame_start ? '0 : col_r;
  assign cur_slot = in_data.frame_start ? '0 : slot_r;
  assign col_inc  = {1'b0, cur_col} + (COL_W+1)'(1);
  assign row_inc  = {1'b0, cur_row} + (ROW_W+1)'(1);

  always_comb begin
    col_nxt  = col_inc[COL_W-1:0];
    row_nxt  = cur_row;
    slot_nxt = cur_slot;
    if (col_inc >= (COL_W+1)'(width_r)) begin
      col_nxt = '0;
      if (row_inc >= (ROW_W+1)'(height_r)) begin
        row_nxt  = '0;
        slot_nxt = '0;
      end else begin
        row_nxt  = row_inc[ROW_W-1:0];
        slot_nxt = (cur_slot == SLOT_W'(LINE_ROWS - 1)) ? '0 : cur_slot + SLOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      slot_r <= '0;
    end else if (in_acc) begin
      row_r  <= row_nxt;
      col_r  <= col_nxt;
      slot_r <= slot_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Line store: one word per column, one byte per buffered row
  // --------------------------------------------------------------------------
  assign wr_en = advance & s1_valid_r;

  bmb_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_col_r),
    .wdata (wr_word),
    .re    (in_acc),
    .raddr (cur_col),
    .rdata (ram_rdata)
  );

  // A read that meets the write-back of the same column takes the new word
  assign line_word = byp_hit_r ? byp_word_r : ram_rdata;

  always_comb begin
    wr_word = line_word;
    wr_word[s1_slot_r*PIX_W +: PIX_W] = s1_pixel_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      byp_hit_r  <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        byp_hit_r <= wr_en && (cur_col == s1_col_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pixel_r <= in_data.pixel;
      s1_row_r   <= cur_row;
      s1_col_r   <= cur_col;
      s1_slot_r  <= cur_slot;
      byp_word_r <= wr_word;
    end
  end

  // Vertical sum: each buffered slot holds the row `row_gap` rows above; the
  // slot about to be overwritten is the oldest row, six above.
  always_comb begin
    logic [DIST_W-1:0] row_gap;
    vsum = VSUM_W'(s1_pixel_r);
    for (int s = 0; s < LINE_ROWS; s++) begin
      if (s1_slot_r >= SLOT_W'(s)) begin
        row_gap = DIST_W'(s1_slot_r) - DIST_W'(s);
      end else begin
        row_gap = DIST_W'(s1_slot_r) + DIST_W'(LINE_ROWS) - DIST_W'(s);
      end
      if (row_gap == '0) begin
        row_gap = DIST_W'(LINE_ROWS);
      end
      if (row_gap <= DIST_W'(kernel_r - KERN_W'(1)) && s1_row_r >= ROW_W'(row_gap)) begin
        vsum = vsum + VSUM_W'(line_word[s*PIX_W +: PIX_W]);
      end
    end
  end

  assign half_k    = kernel_r >> 1;
  assign s1_crow   = (s1_row_r >= ROW_W'(half_k)) ? s1_row_r - ROW_W'(half_k) : '0;
  assign s1_ccol   = (s1_col_r >= COL_W'(half_k)) ? s1_col_r - COL_W'(half_k) : '0;
  assign s1_inside = (s1_row_r >= ROW_W'(kernel_r - KERN_W'(1))) &&
                     (s1_col_r >= COL_W'(kernel_r - KERN_W'(1)));

  // --------------------------------------------------------------------------
  // Column sums shift once per pixel
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_KERNEL; i++) begin
        colsum_r[i] <= '0;
      end
    end else if (wr_en) begin
      colsum_r[0] <= vsum;
      for (int i = 1; i < MAX_KERNEL; i++) begin
        colsum_r[i] <= colsum_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_crow_r   <= s1_crow;
      s2_ccol_r   <= s1_ccol;
      s2_inside_r <= s1_inside;
    end
  end

  // --------------------------------------------------------------------------
  // Window sum over the newest k column sums
  // --------------------------------------------------------------------------
  always_comb begin
    wsum = '0;
    for (int i = 0; i < MAX_KERNEL; i++) begin
      if (KERN_W'(i) < kernel_r) begin
        wsum = wsum + WSUM_W'(colsum_r[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wsum_r      <= wsum;
      s3_crow_r   <= s2_crow_r;
      s3_ccol_r   <= s2_ccol_r;
      s3_inside_r <= s2_inside_r;
    end
  end

  // --------------------------------------------------------------------------
  // Divide by k^2 through the reciprocal
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (advance) begin
      prod_r      <= PROD_W'(wsum_r) * PROD_W'(kernel_recip(kernel_r));
      s4_crow_r   <= s3_crow_r;
      s4_ccol_r   <= s3_ccol_r;
      s4_inside_r <= s3_inside_r;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.centre_row <= s4_crow_r;
      out_data_r.centre_col <= s4_ccol_r;
      out_data_r.blurred    <= s4_inside_r ? prod_r[DIV_SHIFT +: PIX_W] : '0;
      out_data_r.interior   <= s4_inside_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/bmb_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bmb_checker
// Port-level checks of the box mean blur filter, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bmb_checker import bmb_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire blur_out_t out_data
);

  localparam int PIPE_DEPTH = 5;

  logic [3:0] inflight_r;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid & ~in_stall;
  assign out_acc = out_valid & ~out_stall;

  // Count transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + 4'(in_acc) - 4'(out_acc);
    end
  end

  `BMB_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `BMB_ASSERT_IMPL(a_in_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")
  `BMB_ASSERT_IMPL(a_no_invented, out_valid, inflight_r != 4'd0, "result without an accepted pixel")
  `BMB_ASSERT_IMPL(a_depth, 1'b1, inflight_r <= 4'(PIPE_DEPTH), "more pixels in flight than pipeline stages")

endmodule

bind box_mean_blur bmb_checker u_bmb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the box mean blur filter. A cycle-free predictor
// tracks line rows, column sums and the frame position for every accepted
// pixel, and each result is compared with the oldest prediction. A short
// directed table covers reset values, window extremes and frame restarts,
// followed by a full-width row, a tall frame with the widest window and
// random reconfigured phases. Both channels idle and stall at random.
// Register reads are checked against the shadow configuration.
// ----------------------------------------------------------------------------
module tb_top;
  import bmb_pkg::*;

  localparam int QUIET_LIMIT  = 1000;
  localparam int RANDOM_ITEMS = 300;
  localparam int SETTLE       = 20;

  typedef enum int {PIX_RANDOM, PIX_WHITE, PIX_BLACK, PIX_BINARY} pix_mode_t;

  typedef struct {
    int               count;
    bit               regs_first;
    logic [PIX_W-1:0] pixel;
    logic             fstart;
    bit               fixed;
    logic [ROW_W-1:0] crow;
    logic [COL_W-1:0] ccol;
    logic [PIX_W-1:0] blur;
    logic             intr;
  } dir_row_t;

  typedef struct {
    bit        fixed;
    blur_out_t val;
  } table_want_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  pix_in_t     in_data;
  logic        out_valid;
  logic        out_stall;
  blur_out_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // shadow of the block: line rows, column sums, position, registers
  logic [PIX_W-1:0]  line_mem [LINE_ROWS*MAX_WIDTH];
  int unsigned       col_sums [MAX_KERNEL];
  int unsigned       pos_row;
  int unsigned       pos_col;
  logic [KERN_W-1:0] k_cfg = KERNEL_RST;
  logic [DIM_W-1:0]  w_cfg = WIDTH_RST;
  logic [DIM_W-1:0]  h_cfg = HEIGHT_RST;

  blur_out_t   blur_expect [$];
  table_want_t typed_want [$];
  int          fails;
  int          quiet_cycles;
  bit          calm;

  // count, regs first, pixel, frame start, typed, row, col, blurred, interior
  dir_row_t dir_rows [10] = '{
    '{1,  0, 8'd255, 1'b1, 1, 10'd0, 10'd0, 8'd0,   1'b0},
    '{1,  0, 8'd0,   1'b0, 1, 10'd0, 10'd0, 8'd0,   1'b0},
    '{1,  0, 8'd128, 1'b0, 1, 10'd0, 10'd1, 8'd0,   1'b0},
    '{1,  1, 8'd255, 1'b1, 1, 10'd0, 10'd0, 8'd0,   1'b0},
    '{17, 0, 8'd255, 1'b0, 0, 10'd0, 10'd0, 8'd0,   1'b0},
    '{1,  0, 8'd255, 1'b0, 1, 10'd1, 10'd1, 8'd255, 1'b1},
    '{1,  0, 8'd0,   1'b0, 0, 10'd0, 10'd0, 8'd0,   1'b0},
    '{1,  0, 8'd0,   1'b1, 1, 10'd0, 10'd0, 8'd0,   1'b0},
    '{1,  0, 8'hAA,  1'b0, 0, 10'd0, 10'd0, 8'd0,   1'b0},
    '{1,  0, 8'h55,  1'b0, 0, 10'd0, 10'd0, 8'd0,   1'b0}
  };

  box_mean_blur u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Window mean for one pixel; advances the shadow position and line rows.
  function automatic blur_out_t blur_predict(input pix_in_t p);
    int unsigned r, c, k, half, i, vsum, wsum, nr, nc;
    bit          in_frame;
    blur_out_t   o;
    if (p.frame_start) begin
      pos_row = 0;
      pos_col = 0;
    end
    r = pos_row;
    c = pos_col;
    k = k_cfg;
    half = k / 2;
    vsum = p.pixel;
    for (i = 1; i < k; i++) begin
      if (r >= i && c < MAX_WIDTH)
        vsum += line_mem[((r - i) % LINE_ROWS) * MAX_WIDTH + c];
    end
    if (c < MAX_WIDTH)
      line_mem[(r % LINE_ROWS) * MAX_WIDTH + c] = p.pixel;
    for (i = MAX_KERNEL - 1; i > 0; i--)
      col_sums[i] = col_sums[i - 1];
    col_sums[0] = vsum;
    in_frame = (r + 1 >= k) && (c + 1 >= k);
    wsum = 0;
    for (i = 0; i < k && i < MAX_KERNEL; i++)
      wsum += col_sums[i];
    o.centre_row = ROW_W'(r >= half ? r - half : 0);
    o.centre_col = COL_W'(c >= half ? c - half : 0);
    o.blurred    = in_frame ? PIX_W'(wsum / (k * k)) : '0;
    o.interior   = in_frame;
    nc = c + 1;
    nr = r;
    if (nc >= w_cfg) begin
      nc = 0;
      nr = r + 1;
      if (nr >= h_cfg)
        nr = 0;
    end
    pos_col = nc;
    pos_row = nr;
    return o;
  endfunction

  always @(posedge clk) begin : stream_check
    blur_out_t   want;
    blur_out_t   got;
    table_want_t slot;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = blur_predict(in_data);
        slot = typed_want.pop_front();
        if (slot.fixed)
          want = slot.val;
        blur_expect.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (blur_expect.size() == 0) begin
          $display("%0t: unexpected transaction row=%0d col=%0d blurred=%0d interior=%0b",
                   $time, got.centre_row, got.centre_col, got.blurred, got.interior);
          fails++;
        end else begin
          want = blur_expect.pop_front();
          if (got.centre_row !== want.centre_row) begin
            $display("%0t: centre_row expected %0d got %0d", $time,
                     want.centre_row, got.centre_row);
            fails++;
          end
          if (got.centre_col !== want.centre_col) begin
            $display("%0t: centre_col expected %0d got %0d", $time,
                     want.centre_col, got.centre_col);
            fails++;
          end
          if (got.blurred !== want.blurred) begin
            $display("%0t: blurred expected %0d got %0d", $time, want.blurred, got.blurred);
            fails++;
          end
          if (got.interior !== want.interior) begin
            $display("%0t: interior expected %0b got %0b", $time,
                     want.interior, got.interior);
            fails++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: hold stall for a random count, then take one transaction.
  initial begin : stall_gen
    int n;
    out_stall = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_pixel(input pix_in_t p, input bit fixed, input blur_out_t want);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    typed_want.push_back('{fixed, want});
    in_valid <= 1'b1;
    in_data  <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic stream_pixels(input int n, input pix_mode_t mode, input bit fs_first,
                               input bit noise);
    pix_in_t p;
    for (int j = 0; j < n; j++) begin
      case (mode)
        PIX_WHITE:  p.pixel = 8'hFF;
        PIX_BLACK:  p.pixel = 8'h00;
        PIX_BINARY: p.pixel = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        default:    p.pixel = PIX_W'($urandom_range(0, 255));
      endcase
      p.frame_start = (j == 0 && fs_first) || (noise && $urandom_range(0, 149) == 0);
      send_pixel(p, 1'b0, '0);
    end
  endtask

  // Stop the input and wait until every predicted transaction has come out.
  // The first edge lets the last accepted pixel reach the expected queue.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (blur_expect.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [31:0] val);
    logic [31:0] unused;
    cfg_access(1'b1, idx, val, unused);
    case (idx)
      REG_KERNEL: if (val >= 3 && val[0] && val <= MAX_KERNEL) k_cfg = val[KERN_W-1:0];
      REG_WIDTH:  if (val >= DIM_MIN && val <= MAX_WIDTH) w_cfg = val[DIM_W-1:0];
      REG_HEIGHT: if (val >= DIM_MIN && val <= MAX_HEIGHT) h_cfg = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_readback();
    logic [1:0]  regs [3] = '{REG_KERNEL, REG_WIDTH, REG_HEIGHT};
    logic [31:0] got;
    logic [31:0] want;
    int          n;
    for (n = 0; n < 3; n++) begin
      cfg_access(1'b0, regs[n], '0, got);
      case (regs[n])
        REG_KERNEL: want = 32'(k_cfg);
        REG_WIDTH:  want = 32'(w_cfg);
        default:    want = 32'(h_cfg);
      endcase
      if (got !== want) begin
        $display("%0t: register %0d read expected %0d got %0d", $time, regs[n], want, got);
        fails++;
      end
    end
  endtask

  initial begin : main_seq
    int          sent;
    int          n;
    logic [DIM_W-1:0] old_w;
    foreach (line_mem[i]) line_mem[i] = '0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    calm     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].regs_first) begin
        drain();
        cfg_readback();
        // out-of-range and even values must leave the registers alone
        cfg_write(REG_KERNEL, 0);
        cfg_write(REG_KERNEL, 4);
        cfg_write(REG_KERNEL, 1);
        cfg_write(REG_KERNEL, 9);
        cfg_write(REG_KERNEL, KERNEL_7);
        cfg_write(REG_KERNEL, KERNEL_3);
        cfg_write(REG_WIDTH, 7);
        cfg_write(REG_WIDTH, 1025);
        cfg_write(REG_WIDTH, 1024);
        cfg_write(REG_WIDTH, 8);
        cfg_write(REG_HEIGHT, 7);
        cfg_write(REG_HEIGHT, 1025);
        cfg_write(REG_HEIGHT, 1024);
        cfg_write(REG_HEIGHT, 8);
        cfg_readback();
      end
      repeat (dir_rows[i].count)
        send_pixel('{dir_rows[i].pixel, dir_rows[i].fstart}, dir_rows[i].fixed,
                   '{dir_rows[i].crow, dir_rows[i].ccol, dir_rows[i].blur, dir_rows[i].intr});
    end

    // widest row: run through column 1023 and wrap into the next row
    drain();
    cfg_write(REG_WIDTH, MAX_WIDTH);
    cfg_write(REG_HEIGHT, 8);
    cfg_write(REG_KERNEL, KERNEL_3);
    cfg_readback();
    stream_pixels(MAX_WIDTH + 16, PIX_RANDOM, 1'b1, 1'b0);

    // tall frame at minimum width: enough rows for the widest window
    drain();
    cfg_write(REG_WIDTH, 8);
    cfg_write(REG_HEIGHT, MAX_HEIGHT);
    cfg_write(REG_KERNEL, KERNEL_7);
    cfg_readback();
    calm = 1'b1;
    stream_pixels(8 * 10, PIX_RANDOM, 1'b1, 1'b0);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      old_w = w_cfg;
      if ($urandom_range(0, 2) != 0)
        cfg_write(REG_KERNEL, $urandom_range(0, 5) == 0 ? $urandom_range(0, 15)
                                                         : 2 * $urandom_range(1, 3) + 1);
      if ($urandom_range(0, 2) != 0)
        cfg_write(REG_WIDTH, $urandom_range(0, 5) == 0 ? $urandom_range(0, 2047)
                                                        : $urandom_range(8, 24));
      if ($urandom_range(0, 2) != 0)
        cfg_write(REG_HEIGHT, $urandom_range(0, 5) == 0 ? $urandom_range(0, 2047)
                                                         : $urandom_range(8, 16));
      if ($urandom_range(0, 3) == 0)
        cfg_readback();
      calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 300);
      // a wider row would read columns the current frame never wrote: restart
      stream_pixels(n, pix_mode_t'($urandom_range(0, 3)),
                    w_cfg > old_w || $urandom_range(0, 3) == 0, 1'b1);
      sent += n;
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (blur_expect.size() != 0) begin
      $display("%0t: pending transactions expected 0 got %0d", $time, blur_expect.size());
      fails++;
    end
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bmb_pkg.sv
rtl/bmb_ram.sv
rtl/box_mean_blur.sv
rtl/bmb_checker.sv
sim/tb_top.sv
